/* rtl/tbb_pkg.sv */
// tbb_pkg: shared constants, types and helpers for the threshold bounding box
// no dependencies; imported by every rtl file of the block
package tbb_pkg;

  localparam int MAX_RANK      = 4;
  localparam int INDEX_BITS    = 16;
  localparam int SAMPLE_BITS   = 32;
  localparam int RANK_BITS     = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int DIM_BITS      = 2;
  localparam int COUNT_BITS    = 3;
  localparam int SIZE_BITS     = 17;
  localparam int THRESH_BITS   = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int OUT_IDX_BITS  = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIM_COUNT = 3'd0,
    CFG_SIZE_DIM0 = 3'd1,
    CFG_SIZE_DIM1 = 3'd2,
    CFG_SIZE_DIM2 = 3'd3,
    CFG_SIZE_DIM3 = 3'd4,
    CFG_LOW_THR   = 3'd5,
    CFG_HIGH_THR  = 3'd6
  } cfg_reg_e;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [RANK_BITS-1:0]  rank_t;

  typedef struct packed {
    rank_t                              rank_m1;
    index_t [MAX_RANK-1:0]              last;
    logic signed [THRESH_BITS-1:0]      low;
    logic signed [THRESH_BITS-1:0]      high;
  } tbb_cfg_t;

  typedef struct packed {
    rank_t                 rank_m1;
    logic                  hit;
    index_t [MAX_RANK-1:0] least;
    index_t [MAX_RANK-1:0] greatest;
  } tbb_summary_t;

  localparam logic [SIZE_BITS:0] SIZE_CAP = (SIZE_BITS+1)'(1) << INDEX_BITS;

  // last valid index of a dimension from its written size
  function automatic index_t last_of(logic [SIZE_BITS-1:0] size);
    logic [SIZE_BITS:0] s;
    s = {1'b0, size};
    if (s == '0) begin
      last_of = '0;
    end else if (s > SIZE_CAP) begin
      last_of = '1;
    end else begin
      last_of = INDEX_BITS'(s - (SIZE_BITS+1)'(1));
    end
  endfunction

  // dimensions in use minus one, from the written count
  function automatic rank_t rank_of(logic [COUNT_BITS-1:0] cnt);
    logic [COUNT_BITS:0] r;
    r = {1'b0, cnt};
    if (r == '0) begin
      r = (COUNT_BITS+1)'(1);
    end else if (r > (COUNT_BITS+1)'(MAX_RANK)) begin
      r = (COUNT_BITS+1)'(MAX_RANK);
    end
    rank_of = RANK_BITS'(r - (COUNT_BITS+1)'(1));
  endfunction

endpackage

/* rtl/tbb_if.sv */
// tbb_if: valid/ready stream interfaces for samples and box results
// depends on tbb_pkg
interface tbb_sample_if
  import tbb_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tbb_result_if
  import tbb_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [DIM_BITS-1:0]     dimension;
  logic [OUT_IDX_BITS-1:0] start_index;
  logic [OUT_IDX_BITS-1:0] stop_index;
  logic                    found;
  logic                    last;

  modport source (output valid, output dimension, output start_index, output stop_index,
                  output found, output last, input ready);
  modport sink   (input valid, input dimension, input start_index, input stop_index,
                  input found, input last, output ready);
endinterface

/* rtl/tbb_front.sv */
// tbb_front: accepts samples, tracks position and per-dimension min/max of hits
// depends on tbb_pkg and tbb_if; pushes one run summary per completed array
module tbb_front
  import tbb_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tbb_cfg_t       cfg_i,
  tbb_sample_if.sink     sample_i,
  input  logic           full_i,
  output logic           push_o,
  output tbb_summary_t   summary_o
);

  index_t [MAX_RANK-1:0] pos_q, pos_d;
  index_t [MAX_RANK-1:0] least_q, least_d;
  index_t [MAX_RANK-1:0] greatest_q, greatest_d;
  logic                  any_hit_q, any_hit_d;

  logic                  accept;
  logic                  hit;
  logic                  at_end;
  logic [MAX_RANK-1:0]   in_use;
  logic [MAX_RANK-1:0]   wrap;
  logic [MAX_RANK-1:0]   carry;
  index_t [MAX_RANK-1:0] clamped;
  index_t [MAX_RANK-1:0] least_n;
  index_t [MAX_RANK-1:0] greatest_n;
  logic                  c;

  assign sample_i.ready = !full_i;
  assign accept         = sample_i.valid && sample_i.ready;
  assign hit            = (sample_i.sample >= cfg_i.low) && (sample_i.sample <= cfg_i.high);

  always_comb begin
    c = 1'b1;
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      in_use[d]  = (RANK_BITS'(d) <= cfg_i.rank_m1);
      wrap[d]    = (pos_q[d] >= cfg_i.last[d]);
      clamped[d] = wrap[d] ? cfg_i.last[d] : pos_q[d];
      carry[d]   = c;
      c          = c && (wrap[d] || !in_use[d]);
    end
    at_end = &(wrap | ~in_use);
  end

  always_comb begin
    for (int d = 0; d < MAX_RANK; d++) begin
      least_n[d]    = least_q[d];
      greatest_n[d] = greatest_q[d];
      if (hit && in_use[d]) begin
        if (clamped[d] < least_q[d]) begin
          least_n[d] = clamped[d];
        end
        if (clamped[d] > greatest_q[d]) begin
          greatest_n[d] = clamped[d];
        end
      end
    end
  end

  always_comb begin
    pos_d      = pos_q;
    least_d    = least_q;
    greatest_d = greatest_q;
    any_hit_d  = any_hit_q;
    if (accept) begin
      if (at_end) begin
        pos_d      = '0;
        least_d    = '1;
        greatest_d = '0;
        any_hit_d  = 1'b0;
      end else begin
        least_d    = least_n;
        greatest_d = greatest_n;
        any_hit_d  = any_hit_q || hit;
        for (int d = 0; d < MAX_RANK; d++) begin
          if (carry[d] && in_use[d]) begin
            pos_d[d] = wrap[d] ? '0 : pos_q[d] + INDEX_BITS'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      least_q    <= '1;
      greatest_q <= '0;
      any_hit_q  <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      least_q    <= least_d;
      greatest_q <= greatest_d;
      any_hit_q  <= any_hit_d;
    end
  end

  assign push_o             = accept && at_end;
  assign summary_o.rank_m1  = cfg_i.rank_m1;
  assign summary_o.hit      = any_hit_q || hit;
  assign summary_o.least    = least_n;
  assign summary_o.greatest = greatest_n;

endmodule

/* rtl/tbb_queue.sv */
// tbb_queue: small fifo of run summaries between front and back
// depends on tbb_pkg
module tbb_queue
  import tbb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  tbb_summary_t push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output tbb_summary_t head_o
);

  tbb_summary_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]         wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]         rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]           count_q, count_d;
  logic                         do_push;
  logic                         do_pop;

  assign full_o  = (count_q == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (QPTR_BITS+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QPTR_BITS+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/tbb_back.sv */
// tbb_back: walks a run summary; one start/stop beat per dimension in use
// one beat if no hit; depends on tbb_pkg and tbb_if; output is registered
module tbb_back
  import tbb_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         empty_i,
  input  tbb_summary_t head_i,
  output logic         pop_o,
  tbb_result_if.source result_o
);

  logic                    valid_q, valid_d;
  rank_t                   idx_q, idx_d;
  logic [DIM_BITS-1:0]     dim_q;
  logic [OUT_IDX_BITS-1:0] start_q;
  logic [OUT_IDX_BITS-1:0] stop_q;
  logic                    found_q;
  logic                    last_q;
  logic                    load;
  logic                    take;
  logic                    last_beat;

  assign load      = !valid_q || result_o.ready;
  assign take      = load && !empty_i;
  assign last_beat = !head_i.hit || (idx_q == head_i.rank_m1);
  assign pop_o     = take && last_beat;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !empty_i;
    end
    if (take) begin
      idx_d = last_beat ? '0 : idx_q + RANK_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (head_i.hit) begin
        dim_q   <= DIM_BITS'(idx_q);
        start_q <= OUT_IDX_BITS'(head_i.least[idx_q]);
        stop_q  <= OUT_IDX_BITS'(head_i.greatest[idx_q]);
        found_q <= 1'b1;
      end else begin
        dim_q   <= '0;
        start_q <= '0;
        stop_q  <= '0;
        found_q <= 1'b0;
      end
      last_q <= last_beat;
    end
  end

  assign result_o.valid       = valid_q;
  assign result_o.dimension   = dim_q;
  assign result_o.start_index = start_q;
  assign result_o.stop_index  = stop_q;
  assign result_o.found       = found_q;
  assign result_o.last        = last_q;

endmodule

/* rtl/threshold_bounding_box_top.sv */
// threshold bounding box: a run's results leave via the summary queue and the output register
// throughput: one sample per cycle unless the queue is full; each run ends in one result beat
//   per dimension in use (one if none was in range), one per cycle while result ready is high
// a two-entry summary queue decouples sampling from result delivery; sample ready drops when full
// reset (async, active low): clears run state, queue and output; registers to their defaults
module threshold_bounding_box_top
  import tbb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  tbb_sample_if.sink               sample_i,
  tbb_result_if.source             result_o
);

  tbb_cfg_t     cfg_q;
  logic         push;
  tbb_summary_t push_data;
  logic         full;
  logic         pop;
  logic         empty;
  tbb_summary_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rank_m1 <= rank_of(COUNT_BITS'(2));
      cfg_q.last    <= '0;
      cfg_q.low     <= '0;
      cfg_q.high    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIM_COUNT: cfg_q.rank_m1 <= rank_of(cfg_wdata_i[COUNT_BITS-1:0]);
        CFG_SIZE_DIM0: cfg_q.last[0] <= last_of(cfg_wdata_i[SIZE_BITS-1:0]);
        CFG_SIZE_DIM1: cfg_q.last[1] <= last_of(cfg_wdata_i[SIZE_BITS-1:0]);
        CFG_SIZE_DIM2: cfg_q.last[2] <= last_of(cfg_wdata_i[SIZE_BITS-1:0]);
        CFG_SIZE_DIM3: cfg_q.last[3] <= last_of(cfg_wdata_i[SIZE_BITS-1:0]);
        CFG_LOW_THR:   cfg_q.low     <= cfg_wdata_i[THRESH_BITS-1:0];
        CFG_HIGH_THR:  cfg_q.high    <= cfg_wdata_i[THRESH_BITS-1:0];
        default:       ;
      endcase
    end
  end

  tbb_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .sample_i  (sample_i),
    .full_i    (full),
    .push_o    (push),
    .summary_o (push_data)
  );

  tbb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  tbb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

/* tb/threshold_bounding_box_top_tb.sv */
// testbench for threshold_bounding_box_top: directed table, a stall, then random config and sample phases
// beats are checked against typed rows or an in-bench box tracker; needs tbb_pkg, tbb_if and the block
module threshold_bounding_box_top_tb
  import tbb_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [DIM_BITS-1:0]     dimension;
    logic [OUT_IDX_BITS-1:0] start_index;
    logic [OUT_IDX_BITS-1:0] stop_index;
    logic                    found;
    logic                    last;
  } box_beat_t;

  typedef enum logic {
    ROW_WRITE,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    cfg_reg_e               addr;
    logic [31:0]            value;
    logic [1:0]             n_typed;
    box_beat_t [1:0]        typed;
  } plan_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  tbb_sample_if sample_bus ();
  tbb_result_if result_bus ();

  threshold_bounding_box_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_bus),
    .result_o    (result_bus)
  );

  // box tracker copy of the registers and the run state
  logic [COUNT_BITS-1:0]         cfg_rank_raw;
  logic [SIZE_BITS-1:0]          cfg_size [MAX_RANK];
  logic signed [THRESH_BITS-1:0] cfg_low;
  logic signed [THRESH_BITS-1:0] cfg_high;
  index_t                        run_pos [MAX_RANK];
  index_t                        run_least [MAX_RANK];
  index_t                        run_greatest [MAX_RANK];
  logic                          run_hit;
  box_beat_t                     run_result [MAX_RANK];

  box_beat_t bbox_pending[$];
  plan_row_t plan[$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_req;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic box_beat_t make_beat(int d, index_t a, index_t b, logic f, logic l);
    box_beat_t r;
    r.dimension = DIM_BITS'(d);
    r.start_index = a;
    r.stop_index = b;
    r.found = f;
    r.last = l;
    return r;
  endfunction

  function automatic int dims_in_use();
    int r;
    r = int'(cfg_rank_raw);
    if (r < 1) r = 1;
    if (r > MAX_RANK) r = MAX_RANK;
    return r;
  endfunction

  function automatic index_t final_index(int d);
    if (cfg_size[d] == 0) return '0;
    if (cfg_size[d] > 65536) return '1;
    return index_t'(cfg_size[d] - 1);
  endfunction

  function automatic void bbox_clear();
    for (int d = 0; d < MAX_RANK; d++) begin
      run_pos[d] = '0;
      run_least[d] = '1;
      run_greatest[d] = '0;
    end
    run_hit = 1'b0;
  endfunction

  // advances the run by one sample; fills run_result and returns the beat count
  function automatic int bbox_advance(logic signed [SAMPLE_BITS-1:0] v);
    int     rank;
    logic   done;
    index_t p;
    rank = dims_in_use();
    done = 1'b1;
    if (v >= cfg_low && v <= cfg_high) begin
      for (int d = 0; d < rank; d++) begin
        p = (run_pos[d] > final_index(d)) ? final_index(d) : run_pos[d];
        if (p < run_least[d]) run_least[d] = p;
        if (p > run_greatest[d]) run_greatest[d] = p;
      end
      run_hit = 1'b1;
    end
    for (int d = 0; d < rank; d++) begin
      if (run_pos[d] < final_index(d)) done = 1'b0;
    end
    if (!done) begin
      for (int d = rank - 1; d >= 0; d--) begin
        if (run_pos[d] >= final_index(d)) begin
          run_pos[d] = '0;
        end else begin
          run_pos[d] = run_pos[d] + index_t'(1);
          break;
        end
      end
      return 0;
    end
    if (!run_hit) begin
      run_result[0] = make_beat(0, '0, '0, 1'b0, 1'b1);
      bbox_clear();
      return 1;
    end
    for (int d = 0; d < rank; d++) begin
      run_result[d] = make_beat(d, run_least[d], run_greatest[d], 1'b1, d == rank - 1);
    end
    bbox_clear();
    return rank;
  endfunction

  function automatic void plan_add(row_kind_e k, cfg_reg_e a, logic [31:0] v, int n = 0,
                                   box_beat_t t0 = '0, box_beat_t t1 = '0);
    plan_row_t r;
    r.kind = k;
    r.addr = a;
    r.value = v;
    r.n_typed = 2'(n);
    r.typed[0] = t0;
    r.typed[1] = t1;
    plan.push_back(r);
  endfunction

  // random upper bits above the register width, added half the time, which the block must drop
  function automatic logic [31:0] with_junk(logic [31:0] v, int bits);
    logic [31:0] junk;
    junk = $urandom_range(1) ? ($urandom << bits) : 32'd0;
    return junk | v;
  endfunction

  function automatic logic [31:0] pick_sample();
    longint lo;
    longint hi;
    longint span;
    lo = cfg_low;
    hi = cfg_high;
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3, 4, 5: begin
        span = (hi >= lo && hi - lo < 300) ? hi - lo : 300;
        return 32'(lo + longint'($urandom_range(0, 32'(span))));
      end
      default: return 32'(($urandom_range(1) ? lo : hi) + longint'($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  task automatic reg_write(cfg_reg_e a, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= a;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (a)
      CFG_DIM_COUNT: cfg_rank_raw = v[COUNT_BITS-1:0];
      CFG_SIZE_DIM0, CFG_SIZE_DIM1, CFG_SIZE_DIM2, CFG_SIZE_DIM3:
        cfg_size[int'(a) - int'(CFG_SIZE_DIM0)] = v[SIZE_BITS-1:0];
      CFG_LOW_THR:   cfg_low = v;
      CFG_HIGH_THR:  cfg_high = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic settle();
    sample_bus.valid <= 1'b0;
    do @(posedge clk_i); while (bbox_pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic feed_sample(logic [31:0] v, int n_typed, box_beat_t [1:0] typed);
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.sample <= v;
    do @(posedge clk_i); while (sample_bus.ready !== 1'b1);
    n = bbox_advance(v);
    if (n_typed != 0) begin
      for (int i = 0; i < n_typed; i++) bbox_pending.push_back(typed[i]);
    end else begin
      for (int i = 0; i < n; i++) bbox_pending.push_back(run_result[i]);
    end
  endtask

  task automatic shuffle_config();
    logic [31:0] size;
    logic [31:0] lo;
    logic [31:0] hi;
    if ($urandom_range(9) < 7) begin
      reg_write(CFG_DIM_COUNT, with_junk($urandom_range(7), COUNT_BITS));
    end
    for (int d = 0; d < MAX_RANK; d++) begin
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(19))
          0: size = 0;
          1: size = 65536;
          2: size = 131071;
          3: size = 65535;
          default: size = $urandom_range(1, 4);
        endcase
        reg_write(cfg_reg_e'(int'(CFG_SIZE_DIM0) + d), with_junk(size, SIZE_BITS));
      end
    end
    case ($urandom_range(9))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = $urandom;
        hi = lo - $urandom_range(1, 50);
      end
      2: begin
        lo = $urandom;
        hi = $urandom;
      end
      3: begin
        lo = $urandom;
        hi = lo + $urandom_range(100);
      end
      default: begin
        lo = $urandom_range(400) - 200;
        hi = lo + $urandom_range(300);
      end
    endcase
    if ($urandom_range(9) < 7) reg_write(CFG_LOW_THR, lo);
    if ($urandom_range(9) < 7) reg_write(CFG_HIGH_THR, hi);
  endtask

  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        result_bus.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end
      result_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    box_beat_t want;
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (bbox_pending.size() == 0) begin
        $error("result beat with nothing expected: dimension %0d start %0d stop %0d",
               result_bus.dimension, result_bus.start_index, result_bus.stop_index);
        error_count++;
      end else begin
        want = bbox_pending.pop_front();
        check_field("dimension", 16'(want.dimension), 16'(result_bus.dimension));
        check_field("start_index", want.start_index, result_bus.start_index);
        check_field("stop_index", want.stop_index, result_bus.stop_index);
        check_field("found", 16'(want.found), 16'(result_bus.found));
        check_field("last", 16'(want.last), 16'(result_bus.last));
      end
    end
  end

  initial begin
    #400_000;
    $display("** threshold_bounding_box_top: FAILED **");
    $finish;
  end

  initial begin : main
    box_beat_t whole;
    box_beat_t whole_last;
    box_beat_t none;
    int        fed;
    int        n;

    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.sample = '0;
    hold_req = 1'b0;
    error_count = 0;
    send_idle_pct = 32;
    recv_idle_pct = 64;

    cfg_rank_raw = 3'd2;
    for (int d = 0; d < MAX_RANK; d++) cfg_size[d] = 17'd1;
    cfg_low = '0;
    cfg_high = '0;
    bbox_clear();

    whole = make_beat(0, '0, '0, 1'b1, 1'b0);
    whole_last = make_beat(1, '0, '0, 1'b1, 1'b1);
    none = make_beat(0, '0, '0, 1'b0, 1'b1);

    // after reset: two dimensions of size one, range [0, 0]
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd0, 2, whole, whole_last);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd1, 1, none);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'hFFFF_FFFF, 1, none);
    // widest range, extreme samples
    plan_add(ROW_WRITE, CFG_LOW_THR, 32'h8000_0000);
    plan_add(ROW_WRITE, CFG_HIGH_THR, 32'h7FFF_FFFF);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'h8000_0000, 2, whole, whole_last);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'h7FFF_FFFF, 2, whole, whole_last);
    // zero rank acts as one, empty range
    plan_add(ROW_WRITE, CFG_DIM_COUNT, 32'd0);
    plan_add(ROW_WRITE, CFG_SIZE_DIM0, 32'd3);
    plan_add(ROW_WRITE, CFG_LOW_THR, 32'd5);
    plan_add(ROW_WRITE, CFG_HIGH_THR, 32'd4);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd7);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd7);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd7, 1, none);
    // rank above the maximum, zero size
    plan_add(ROW_WRITE, CFG_DIM_COUNT, 32'd7);
    plan_add(ROW_WRITE, CFG_SIZE_DIM0, 32'd2);
    plan_add(ROW_WRITE, CFG_SIZE_DIM1, 32'd0);
    plan_add(ROW_WRITE, CFG_SIZE_DIM2, 32'd1);
    plan_add(ROW_WRITE, CFG_SIZE_DIM3, 32'd2);
    plan_add(ROW_WRITE, CFG_LOW_THR, 32'hFFFF_FFF6);
    plan_add(ROW_WRITE, CFG_HIGH_THR, 32'd10);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd100);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd3);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'hFFFF_FFF6);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd11);
    // oversized and largest size, then shrink mid-run so the position wraps
    plan_add(ROW_WRITE, CFG_DIM_COUNT, 32'd1);
    plan_add(ROW_WRITE, CFG_SIZE_DIM0, 32'd131071);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd50);
    plan_add(ROW_WRITE, CFG_SIZE_DIM0, 32'd65536);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'hFFFF_FFFB);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd0);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd99);
    plan_add(ROW_WRITE, CFG_SIZE_DIM0, 32'd2);
    plan_add(ROW_SAMPLE, CFG_DIM_COUNT, 32'd10);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        reg_write(plan[i].addr, plan[i].value);
      end else begin
        feed_sample(plan[i].value, plan[i].n_typed, plan[i].typed);
      end
    end

    // every sample ends a four-dimension run (four beats, or one if out of range) while the receiver holds off
    settle();
    reg_write(CFG_DIM_COUNT, 32'd4);
    for (int d = 0; d < MAX_RANK; d++) reg_write(cfg_reg_e'(int'(CFG_SIZE_DIM0) + d), 32'd1);
    reg_write(CFG_LOW_THR, 32'hFFFF_FF9C);
    reg_write(CFG_HIGH_THR, 32'd100);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    repeat (30) feed_sample(pick_sample(), 0, '0);

    fed = 0;
    while (fed < 420) begin
      settle();
      if (fed < 140) begin
        send_idle_pct = 32;
        recv_idle_pct = 64;
      end else if (fed < 280) begin
        send_idle_pct = 64;
        recv_idle_pct = 32;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      shuffle_config();
      n = $urandom_range(15, 45);
      repeat (n) feed_sample(pick_sample(), 0, '0);
      fed += n;
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (bbox_pending.size() != 0) begin
      $error("%0d result beats never arrived", bbox_pending.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("** threshold_bounding_box_top: PASSED **");
    end else begin
      $display("** threshold_bounding_box_top: FAILED **");
    end
    $finish;
  end

endmodule
